@@ sv/sample_voice_mixer_defines.svh @@
`ifndef SAMPLE_VOICE_MIXER_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/svm_pkg.sv @@
`timescale 1ns / 1ps

package svm_pkg;

  localparam int MAX_VOICES   = 64;
  localparam int SLOT_COUNT   = 2048;
  localparam int SAMPLE_WORDS = 65536;

  localparam int VOICE_AW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int COUNT_W   = $clog2(MAX_VOICES + 1);
  localparam int SLOT_AW   = $clog2(SLOT_COUNT);
  localparam int SAMPLE_AW = $clog2(SAMPLE_WORDS);

  localparam int START_W  = 16;
  localparam int FRAMES_W = 17;
  localparam int CHAN_W   = 4;
  localparam int SMP_W    = 16;
  localparam int BASE_W   = 22;

  localparam logic signed [SMP_W:0] SAT_MAX = 17'sd32767;
  localparam logic signed [SMP_W:0] SAT_MIN = -17'sd32768;

  typedef enum logic [1:0] {
    FUNC_WRITE_SAMPLE = 2'd0,
    FUNC_WRITE_SLOT   = 2'd1,
    FUNC_TRIGGER      = 2'd2,
    FUNC_RENDER       = 2'd3
  } svm_func_e;

  typedef struct packed {
    logic                valid;
    logic [CHAN_W-1:0]   channels;
    logic [FRAMES_W-1:0] frames;
    logic [START_W-1:0]  start;
  } svm_slot_t;

  typedef struct packed {
    logic [SLOT_AW-1:0]  slot;
    logic [FRAMES_W-1:0] pos;
  } svm_voice_t;

  function automatic logic signed [SMP_W-1:0] sat16(logic signed [SMP_W:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SMP_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SMP_W-1:0];
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/svm_ram.sv @@
`timescale 1ns / 1ps

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sample_voice_mixer.sv @@
// Sample-playback voice mixer. Sample writes, descriptor writes and triggers are
// transactions on the input stream; a render transaction mixes all playing voices
// and returns one stereo frame plus the count of voices still active. Sample and
// descriptor writes complete in the idle state; a trigger with room left passes
// through a second state that appends a voice for a valid slot. In a render each
// voice walks one shared path: voice list read, slot table read, address
// multiply-add, and two reads through the single read port of the sample store,
// then the saturating left and right adds (a voice that has run out skips the
// reads and adds). After reset all SLOT_COUNT (2048) slots are swept clear before
// the first transaction is taken. A finished frame waits in an output register,
// so the next non-render transaction is taken while it is pending.
`timescale 1ns / 1ps
`include "sample_voice_mixer_defines.svh"

module sample_voice_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_addr[15:0], sample_value[31:16], slot[42:32], slot_start[58:43],
  // slot_frames[75:59], slot_channels[79:76], slot_valid[80], zero pad
  input  logic [87:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out[15:0], right_out[31:16], voices_left[38:32], zero pad
  output logic [39:0] m_axis_tdata
);

  localparam int SlotW  = svm_pkg::SLOT_AW;
  localparam int VoiceW = $bits(svm_pkg::svm_voice_t);
  localparam int DescW  = $bits(svm_pkg::svm_slot_t);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_TRIG   = 10'b0000000100,
    S_RVOICE = 10'b0000001000,
    S_RSLOT  = 10'b0000010000,
    S_RDESC  = 10'b0000100000,
    S_RLEFT  = 10'b0001000000,
    S_RRIGHT = 10'b0010000000,
    S_RMIX   = 10'b0100000000,
    S_RDONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic                                  accept;
  svm_pkg::svm_func_e                    in_func;
  logic [15:0]                           in_sample_addr;
  logic signed [svm_pkg::SMP_W-1:0]      in_sample_value;
  logic [10:0]                           in_slot;
  logic [SlotW-1:0]                      in_slot_idx;
  logic                                  slot_ok;
  svm_pkg::svm_slot_t                    in_desc;

  logic [SlotW-1:0]                      clr_q;
  logic [SlotW-1:0]                      trig_slot_q;
  logic [svm_pkg::COUNT_W-1:0]           count_q, idx_q, kept_q;
  logic [SlotW-1:0]                      vslot_q;
  logic [svm_pkg::FRAMES_W-1:0]          vpos_q, pos_next;
  logic [svm_pkg::FRAMES_W-1:0]          dfr_q;
  logic [svm_pkg::CHAN_W-1:0]            dch_q, ch_eff;
  logic [svm_pkg::BASE_W-1:0]            base_q, base_d;
  logic signed [svm_pkg::SMP_W-1:0]      lsmp_q, rsmp;
  logic signed [svm_pkg::SMP_W-1:0]      left_q, right_q, left_d, right_d;
  logic signed [svm_pkg::SMP_W-1:0]      out_left_q, out_right_q;
  logic [svm_pkg::COUNT_W-1:0]           out_count_q;
  logic                                  out_valid_q, out_load, keep, active;

  logic                                  smp_we, smp_re;
  logic [svm_pkg::SAMPLE_AW-1:0]         smp_waddr, smp_raddr;
  logic [svm_pkg::SMP_W-1:0]             smp_rdata;

  logic                                  slt_we, slt_re;
  logic [SlotW-1:0]                      slt_waddr, slt_raddr;
  svm_pkg::svm_slot_t                    slt_wdata, slt_rdata;

  logic                                  vce_we, vce_re;
  logic [svm_pkg::VOICE_AW-1:0]          vce_waddr, vce_raddr;
  svm_pkg::svm_voice_t                   vce_wdata, vce_rdata;

  assign s_axis_tready   = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid && s_axis_tready;
  assign in_func         = svm_pkg::svm_func_e'(s_axis_tuser);
  assign in_sample_addr  = s_axis_tdata[15:0];
  assign in_sample_value = s_axis_tdata[31:16];
  assign in_slot         = s_axis_tdata[42:32];
  assign in_slot_idx     = SlotW'(32'(in_slot));
  assign slot_ok         = 32'(in_slot) < svm_pkg::SLOT_COUNT;
  assign in_desc.start    = s_axis_tdata[58:43];
  assign in_desc.frames   = s_axis_tdata[75:59];
  assign in_desc.channels = s_axis_tdata[79:76];
  assign in_desc.valid    = s_axis_tdata[80];

  // per-voice arithmetic
  assign ch_eff   = (slt_rdata.channels == '0) ? svm_pkg::CHAN_W'(1) : slt_rdata.channels;
  assign active   = vpos_q < slt_rdata.frames;
  assign base_d   = svm_pkg::BASE_W'(slt_rdata.start)
                  + svm_pkg::BASE_W'(vpos_q) * svm_pkg::BASE_W'(ch_eff);
  assign pos_next = vpos_q + svm_pkg::FRAMES_W'(1);
  assign keep     = pos_next < dfr_q;
  assign rsmp     = (dch_q >= svm_pkg::CHAN_W'(2)) ? smp_rdata : lsmp_q;
  assign left_d   = svm_pkg::sat16({left_q[svm_pkg::SMP_W-1], left_q}
                                   + {lsmp_q[svm_pkg::SMP_W-1], lsmp_q});
  assign right_d  = svm_pkg::sat16({right_q[svm_pkg::SMP_W-1], right_q}
                                   + {rsmp[svm_pkg::SMP_W-1], rsmp});
  assign out_load = (state_q == S_RDONE) && (!out_valid_q || m_axis_tready);

  // memory port steering
  assign smp_we    = accept && (in_func == svm_pkg::FUNC_WRITE_SAMPLE);
  assign smp_waddr = svm_pkg::SAMPLE_AW'(32'(in_sample_addr));
  assign smp_re    = (state_q == S_RLEFT) || (state_q == S_RRIGHT);
  assign smp_raddr = (state_q == S_RLEFT) ? svm_pkg::SAMPLE_AW'(base_q)
                   : svm_pkg::SAMPLE_AW'(base_q) + svm_pkg::SAMPLE_AW'(1);

  assign slt_we    = (state_q == S_CLEAR)
                  || (accept && (in_func == svm_pkg::FUNC_WRITE_SLOT) && slot_ok);
  assign slt_waddr = (state_q == S_CLEAR) ? clr_q : in_slot_idx;
  assign slt_wdata = (state_q == S_CLEAR) ? '0 : in_desc;
  assign slt_re    = (accept && (in_func == svm_pkg::FUNC_TRIGGER)) || (state_q == S_RSLOT);
  assign slt_raddr = (state_q == S_RSLOT) ? vce_rdata.slot : in_slot_idx;

  assign vce_we    = ((state_q == S_TRIG) && slt_rdata.valid) || ((state_q == S_RMIX) && keep);
  assign vce_waddr = (state_q == S_TRIG) ? svm_pkg::VOICE_AW'(count_q)
                                         : svm_pkg::VOICE_AW'(kept_q);
  assign vce_wdata = (state_q == S_TRIG) ? svm_pkg::svm_voice_t'({trig_slot_q,
                                                                  svm_pkg::FRAMES_W'(0)})
                                         : svm_pkg::svm_voice_t'({vslot_q, pos_next});
  assign vce_re    = (state_q == S_RVOICE) && (idx_q != count_q);
  assign vce_raddr = svm_pkg::VOICE_AW'(idx_q);

  svm_ram #(.WIDTH(svm_pkg::SMP_W), .DEPTH(svm_pkg::SAMPLE_WORDS)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (smp_waddr),
    .wdata_i (in_sample_value),
    .re_i    (smp_re),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  svm_ram #(.WIDTH(DescW), .DEPTH(svm_pkg::SLOT_COUNT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slt_we),
    .waddr_i (slt_waddr),
    .wdata_i (slt_wdata),
    .re_i    (slt_re),
    .raddr_i (slt_raddr),
    .rdata_o (slt_rdata)
  );

  svm_ram #(.WIDTH(VoiceW), .DEPTH(svm_pkg::MAX_VOICES)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (vce_we),
    .waddr_i (vce_waddr),
    .wdata_i (vce_wdata),
    .re_i    (vce_re),
    .raddr_i (vce_raddr),
    .rdata_o (vce_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == SlotW'(svm_pkg::SLOT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            svm_pkg::FUNC_WRITE_SAMPLE,
            svm_pkg::FUNC_WRITE_SLOT: state_d = S_IDLE;
            svm_pkg::FUNC_TRIGGER: begin
              if (slot_ok && (count_q < svm_pkg::COUNT_W'(svm_pkg::MAX_VOICES))) begin
                state_d = S_TRIG;
              end
            end
            svm_pkg::FUNC_RENDER: state_d = S_RVOICE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TRIG:   state_d = S_IDLE;
      S_RVOICE: state_d = (idx_q == count_q) ? S_RDONE : S_RSLOT;
      S_RSLOT:  state_d = S_RDESC;
      S_RDESC:  state_d = active ? S_RLEFT : S_RVOICE;
      S_RLEFT:  state_d = S_RRIGHT;
      S_RRIGHT: state_d = S_RMIX;
      S_RMIX:   state_d = S_RVOICE;
      S_RDONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + SlotW'(1);
      end
      if ((state_q == S_TRIG) && slt_rdata.valid) begin
        count_q <= count_q + svm_pkg::COUNT_W'(1);
      end
      if (accept && (in_func == svm_pkg::FUNC_RENDER)) begin
        idx_q  <= '0;
        kept_q <= '0;
      end
      if (((state_q == S_RDESC) && !active) || (state_q == S_RMIX)) begin
        idx_q <= idx_q + svm_pkg::COUNT_W'(1);
      end
      if ((state_q == S_RMIX) && keep) begin
        kept_q <= kept_q + svm_pkg::COUNT_W'(1);
      end
      if (out_load) begin
        count_q     <= kept_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      trig_slot_q <= in_slot_idx;
      left_q      <= '0;
      right_q     <= '0;
    end
    if (state_q == S_RSLOT) begin
      vslot_q <= vce_rdata.slot;
      vpos_q  <= vce_rdata.pos;
    end
    if (state_q == S_RDESC) begin
      dfr_q  <= slt_rdata.frames;
      dch_q  <= slt_rdata.channels;
      base_q <= base_d;
    end
    if (state_q == S_RRIGHT) begin
      lsmp_q <= smp_rdata;
    end
    if (state_q == S_RMIX) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
    if (out_load) begin
      out_left_q  <= left_q;
      out_right_q <= right_q;
      out_count_q <= kept_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_right_q, out_left_q};

  `SVM_ASSERT_IMP(a_count_bound, 1'b1, count_q <= svm_pkg::COUNT_W'(svm_pkg::MAX_VOICES), "voice count above limit")
  `SVM_ASSERT_IMP(a_kept_le_idx, state_q == S_RVOICE, kept_q <= idx_q, "compaction index ahead of walk index")
  `SVM_ASSERT_IMP(a_idx_le_count, state_q == S_RVOICE, idx_q <= count_q, "walk index beyond voice count")
  `SVM_ASSERT_NXT(a_done_to_out, out_load, m_axis_tvalid && (state_q == S_IDLE), "finished frame not presented")

endmodule

@@ bench/sample_voice_mixer_test.sv @@
`timescale 1ns / 1ps

module sample_voice_mixer_test;

  localparam int OP_TARGET    = 1850;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int IDLE_PCT     = 33;
  localparam int CALM_LO      = 600;
  localparam int CALM_HI      = 900;
  localparam int POOL_DEPTH   = 16;
  localparam int PCM_MAX      = 32767;
  localparam int PCM_MIN      = -32768;
  localparam int FRAMES_MAX   = 65536;

  typedef struct {
    svm_pkg::svm_func_e func;
    logic [15:0] addr;
    logic [15:0] value;
    logic [10:0] slot;
    logic [15:0] start;
    logic [16:0] frames;
    logic [3:0]  chans;
    logic        valid;
  } mix_req_t;

  typedef struct packed {
    logic [6:0]  voices;
    logic [15:0] right;
    logic [15:0] left;
  } mix_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // sample_addr, sample_value, slot, slot_start, slot_frames, slot_channels, slot_valid, pad
  logic [87:0] s_axis_tdata = '0;
  // func
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // left_out, right_out, voices_left, pad
  logic [39:0] m_axis_tdata;

  // mirror of the mixer state
  logic [15:0]         pcm_mem [svm_pkg::SAMPLE_WORDS];
  bit                  pcm_seen [svm_pkg::SAMPLE_WORDS];
  svm_pkg::svm_slot_t  slot_tab [svm_pkg::SLOT_COUNT];
  svm_pkg::svm_voice_t voice_q[$];

  mix_req_t    mix_req_q[$];
  mix_frame_t  frame_exp_q[$];
  logic [10:0] slot_pool_q[$];

  int sent_cnt = 0;
  int fail_cnt = 0;
  int stall_cnt = 0;
  bit in_fire = 1'b0;
  bit calm;

  assign calm = (sent_cnt >= CALM_LO) && (sent_cnt < CALM_HI);

  sample_voice_mixer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int clip_pcm(int v);
    if (v > PCM_MAX) return PCM_MAX;
    if (v < PCM_MIN) return PCM_MIN;
    return v;
  endfunction

  function automatic int voice_chans(svm_pkg::svm_slot_t d);
    return (d.channels == '0) ? 1 : int'(d.channels);
  endfunction

  // updates the mirror and queues the frame a render produces
  task automatic mix_apply(mix_req_t r);
    int         left_acc;
    int         right_acc;
    int         ch;
    int         l_smp;
    int         r_smp;
    logic [31:0] base;
    svm_pkg::svm_slot_t  d;
    svm_pkg::svm_voice_t v;
    svm_pkg::svm_voice_t kept_q[$];
    mix_frame_t f;
    case (r.func)
      svm_pkg::FUNC_WRITE_SAMPLE: begin
        pcm_mem[r.addr] = r.value;
        pcm_seen[r.addr] = 1'b1;
      end
      svm_pkg::FUNC_WRITE_SLOT: begin
        slot_tab[r.slot] = '{valid: r.valid, channels: r.chans, frames: r.frames,
                             start: r.start};
      end
      svm_pkg::FUNC_TRIGGER: begin
        if (slot_tab[r.slot].valid && voice_q.size() < svm_pkg::MAX_VOICES) begin
          v.slot = r.slot;
          v.pos = '0;
          voice_q.insert(voice_q.size(), v);
        end
      end
      svm_pkg::FUNC_RENDER: begin
        left_acc = 0;
        right_acc = 0;
        foreach (voice_q[i]) begin
          v = voice_q[i];
          d = slot_tab[v.slot];
          ch = voice_chans(d);
          if (v.pos < d.frames) begin
            base = 32'(d.start) + 32'(v.pos) * ch;
            l_smp = $signed(pcm_mem[base[15:0]]);
            r_smp = l_smp;
            if (ch >= 2) begin
              r_smp = $signed(pcm_mem[base[15:0] + 16'd1]);
            end
            left_acc = clip_pcm(left_acc + l_smp);
            right_acc = clip_pcm(right_acc + r_smp);
            v.pos = v.pos + 17'd1;
          end
          if (v.pos < d.frames) begin
            kept_q.insert(kept_q.size(), v);
          end
        end
        voice_q = kept_q;
        f.left = left_acc[15:0];
        f.right = right_acc[15:0];
        f.voices = 7'(voice_q.size());
        frame_exp_q.insert(frame_exp_q.size(), f);
      end
      default: begin
      end
    endcase
  endtask

  // unused fields carry random bits, the block must ignore them
  function automatic mix_req_t noise_req(svm_pkg::svm_func_e f);
    mix_req_t r;
    r.func = f;
    r.addr = 16'($urandom);
    r.value = 16'($urandom);
    r.slot = 11'($urandom);
    r.start = 16'($urandom);
    r.frames = 17'($urandom_range(0, FRAMES_MAX));
    r.chans = 4'($urandom_range(0, 8));
    r.valid = 1'($urandom);
    return r;
  endfunction

  task automatic emit(mix_req_t r);
    mix_apply(r);
    mix_req_q.insert(mix_req_q.size(), r);
  endtask

  task automatic put_sample(logic [15:0] a, logic [15:0] val);
    mix_req_t r;
    r = noise_req(svm_pkg::FUNC_WRITE_SAMPLE);
    r.addr = a;
    r.value = val;
    emit(r);
  endtask

  task automatic put_slot(logic [10:0] s, logic [15:0] st, logic [16:0] fr,
                          logic [3:0] ch, logic vld);
    mix_req_t r;
    r = noise_req(svm_pkg::FUNC_WRITE_SLOT);
    r.slot = s;
    r.start = st;
    r.frames = fr;
    r.chans = ch;
    r.valid = vld;
    emit(r);
  endtask

  task automatic put_trigger(logic [10:0] s);
    mix_req_t r;
    r = noise_req(svm_pkg::FUNC_TRIGGER);
    r.slot = s;
    emit(r);
  endtask

  // every word a render will read gets written first
  task automatic put_render();
    svm_pkg::svm_slot_t d;
    int          ch;
    logic [31:0] base;
    logic [15:0] a;
    foreach (voice_q[i]) begin
      d = slot_tab[voice_q[i].slot];
      ch = voice_chans(d);
      if (voice_q[i].pos < d.frames) begin
        base = 32'(d.start) + 32'(voice_q[i].pos) * ch;
        a = base[15:0];
        if (!pcm_seen[a]) begin
          put_sample(a, 16'($urandom));
        end
        if (ch >= 2 && !pcm_seen[a + 16'd1]) begin
          put_sample(a + 16'd1, 16'($urandom));
        end
      end
    end
    emit(noise_req(svm_pkg::FUNC_RENDER));
  endtask

  initial begin
    int          pick;
    int          len;
    int          reps;
    logic [10:0] s;
    logic [15:0] st;
    logic [16:0] fr;
    logic [3:0]  ch;
    svm_pkg::svm_voice_t v;
    svm_pkg::svm_slot_t  d;

    foreach (slot_tab[i]) begin
      slot_tab[i] = '0;
    end

    // directed: extremes, wrap, mono and stereo, zero channels and frames
    put_sample(16'd0, 16'h7FFF);
    put_sample(16'd1, 16'h8000);
    put_sample(16'hFFFF, 16'h7FFF);
    put_sample(16'd2, 16'h0001);
    put_slot(11'd0, 16'd0, 17'd2, 4'd1, 1'b1);
    put_slot(11'd2047, 16'hFFFF, 17'd1, 4'd2, 1'b1);
    put_slot(11'd5, 16'd0, 17'd1, 4'd0, 1'b1);
    put_slot(11'd6, 16'd0, 17'd0, 4'd8, 1'b1);
    put_slot(11'd7, 16'd0, 17'(FRAMES_MAX), 4'd8, 1'b0);
    put_slot(11'd1, 16'd1, 17'd1, 4'd1, 1'b1);
    put_render();
    put_trigger(11'd0);
    put_trigger(11'd2047);
    put_trigger(11'd5);
    put_trigger(11'd6);
    put_trigger(11'd7);
    put_trigger(11'd0);
    put_trigger(11'd5);
    put_render();
    put_slot(11'd0, 16'd0, 17'd1, 4'd1, 1'b1);
    put_render();
    put_trigger(11'd1);
    put_trigger(11'd1);
    put_render();

    while (mix_req_q.size() < OP_TARGET) begin
      pick = $urandom_range(0, 199);
      if (voice_q.size() > 32 && pick < 30) begin
        // cut a playing sound short, its voices drain
        v = voice_q[$urandom_range(0, voice_q.size() - 1)];
        d = slot_tab[v.slot];
        len = int'(v.pos) + $urandom_range(0, 4);
        if (len > FRAMES_MAX) begin
          len = FRAMES_MAX;
        end
        put_slot(v.slot, d.start, 17'(len), d.channels, 1'($urandom));
      end else if (pick < 50) begin
        put_sample(16'($urandom), 16'($urandom));
      end else if (pick < 74) begin
        s = 11'($urandom);
        st = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
        len = $urandom_range(0, 99);
        if (len < 70) begin
          fr = 17'($urandom_range(0, 16));
        end else if (len < 90) begin
          fr = 17'($urandom_range(17, 200));
        end else if (len < 97) begin
          fr = 17'($urandom_range(0, FRAMES_MAX));
        end else begin
          fr = 17'(FRAMES_MAX);
        end
        ch = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
        put_slot(s, st, fr, ch, $urandom_range(0, 99) < 85);
        slot_pool_q.insert(slot_pool_q.size(), s);
        if (slot_pool_q.size() > POOL_DEPTH) begin
          void'(slot_pool_q.pop_front());
        end
      end else if (pick < 134) begin
        if (slot_pool_q.size() != 0 && $urandom_range(0, 3) != 0) begin
          put_trigger(slot_pool_q[$urandom_range(0, slot_pool_q.size() - 1)]);
        end else begin
          put_trigger(11'($urandom));
        end
      end else if (pick == 134) begin
        // fill the voice list and run past it
        if (slot_pool_q.size() != 0) begin
          s = slot_pool_q[$urandom_range(0, slot_pool_q.size() - 1)];
          reps = svm_pkg::MAX_VOICES - voice_q.size() + 3;
          repeat (reps) put_trigger(s);
        end
      end else begin
        put_render();
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (mix_req_q.size() != 0 || s_axis_tvalid || frame_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("sample_voice_mixer_test passed");
    end else begin
      $display("sample_voice_mixer_test failed");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    mix_req_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (in_fire || !s_axis_tvalid) begin
      if (mix_req_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        r = mix_req_q.pop_front();
        s_axis_tuser <= r.func;
        s_axis_tdata <= {7'd0, r.valid, r.chans, r.frames, r.start, r.slot, r.value, r.addr};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    mix_frame_t exp_f;
    mix_frame_t got_f;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      sent_cnt <= sent_cnt + 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got_f = m_axis_tdata[38:0];
      if (frame_exp_q.size() == 0) begin
        $error("frame transaction with no expectation waiting: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_f = frame_exp_q.pop_front();
        if (got_f.left !== exp_f.left) begin
          $error("left_out mismatch: expected %0d, actual %0d",
                 $signed(exp_f.left), $signed(got_f.left));
          fail_cnt++;
        end
        if (got_f.right !== exp_f.right) begin
          $error("right_out mismatch: expected %0d, actual %0d",
                 $signed(exp_f.right), $signed(got_f.right));
          fail_cnt++;
        end
        if (got_f.voices !== exp_f.voices) begin
          $error("voices_left mismatch: expected %0d, actual %0d",
                 exp_f.voices, got_f.voices);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("sample_voice_mixer_test failed");
      $finish;
    end
  end

endmodule
